// File: rtl/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg: shared types and codes for the point-in-capsule test
// Region codes, configuration register indexes and the region type used by
// the result channel and the top level.
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int CFG_INDEX_WIDTH = 3;

  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
  typedef logic [1:0] region_t;

  localparam region_t REGION_START = 2'd0;
  localparam region_t REGION_BODY  = 2'd1;
  localparam region_t REGION_END   = 2'd2;

  localparam cfg_index_t REG_START_X    = 3'd0;
  localparam cfg_index_t REG_START_Y    = 3'd1;
  localparam cfg_index_t REG_START_Z    = 3'd2;
  localparam cfg_index_t REG_END_X      = 3'd3;
  localparam cfg_index_t REG_END_Y      = 3'd4;
  localparam cfg_index_t REG_END_Z      = 3'd5;
  localparam cfg_index_t REG_CAP_RADIUS = 3'd6;

endpackage

// File: rtl/pic_channels.sv
// ----------------------------------------------------------------------------
// pic_channels: stream channels of the point-in-capsule test
// The query point channel and the test result channel, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface pic_point_if #(
  parameter int WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] point_x;
  logic signed [WIDTH-1:0] point_y;
  logic signed [WIDTH-1:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                output ready);
endinterface

interface pic_result_if;
  import pic_pkg::*;
  logic    valid;
  logic    ready;
  logic    inside_res;
  region_t region;

  modport source (output valid, output inside_res, output region, input ready);
  modport sink (input valid, input inside_res, input region, output ready);
endinterface

// File: rtl/pic_mul.sv
// ----------------------------------------------------------------------------
// pic_mul: two-stage unsigned multiplier
// Splits both operands into halves, registers the four partial products and
// adds them in the second stage. Advances only when enabled.
// ----------------------------------------------------------------------------
module pic_mul #(
  parameter int WIDTH = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [WIDTH-1:0]     a,
  input  logic [WIDTH-1:0]     b,
  output logic [2*WIDTH-1:0]   p
);
  localparam int H = (WIDTH + 1) / 2;

  logic [H-1:0]   a_lo, a_hi, b_lo, b_hi;
  logic [2*H-1:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic [4*H-1:0] sum;

  assign a_lo = a[H-1:0];
  assign b_lo = b[H-1:0];
  assign a_hi = H'(a >> H);
  assign b_hi = H'(b >> H);

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= a_lo * b_lo;
      pp_lh <= a_lo * b_hi;
      pp_hl <= a_hi * b_lo;
      pp_hh <= a_hi * b_hi;
    end
  end

  assign sum = (4*H)'(pp_ll) + ((4*H)'(pp_lh) << H) + ((4*H)'(pp_hl) << H)
             + ((4*H)'(pp_hh) << (2*H));

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sum[2*WIDTH-1:0];
    end
  end
endmodule

// File: rtl/point_in_capsule_test_top.sv
// ----------------------------------------------------------------------------
// point_in_capsule_test_top: point-in-capsule test
// Decides whether a query point lies inside a capsule held in registers.
// ----------------------------------------------------------------------------
// The block takes one query point per cycle unless the result side stalls
// and returns whether the point lies inside or on the capsule and which part
// of the capsule (start cap, body, end cap) it was tested against, from the
// seven-stage pipeline: coordinate differences, products, dot and cross sums,
// region decision, two stages of split multipliers for the wide squared body
// distance, and the final compare held in the output register. A stall on the
// result side holds the whole pipeline; no transaction is lost. The user must
// write the capsule registers through the configuration port only while no
// transaction is in flight (not enforced); zero-length axes test as spheres.
module point_in_capsule_test_top #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  pic_pkg::cfg_index_t         cfg_index,
  input  logic [COORD_WIDTH-1:0]      cfg_wr_data,
  pic_point_if.sink                   points,
  pic_result_if.source                results
);
  import pic_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;
  localparam int PW   = 2 * DW;
  localparam int SQW  = 2 * W;
  localparam int RRW  = 2 * W - 2;
  localparam int TW   = 2 * W + 3;
  localparam int LW   = 2 * W + 2;
  localparam int CW   = 2 * W + 2;
  localparam int MW   = 2 * W + 1;
  localparam int CMPW = 4 * W + 4;

  logic signed [W-1:0] start_x, start_y, start_z;
  logic signed [W-1:0] end_x, end_y, end_z;
  logic [W-2:0]        cap_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x    <= '0;
      start_y    <= '0;
      start_z    <= '0;
      end_x      <= '0;
      end_y      <= '0;
      end_z      <= '0;
      cap_radius <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_START_X:    start_x    <= cfg_wr_data;
        REG_START_Y:    start_y    <= cfg_wr_data;
        REG_START_Z:    start_z    <= cfg_wr_data;
        REG_END_X:      end_x      <= cfg_wr_data;
        REG_END_Y:      end_y      <= cfg_wr_data;
        REG_END_Z:      end_z      <= cfg_wr_data;
        REG_CAP_RADIUS: cap_radius <= cfg_wr_data[W-2:0];
        default: begin
        end
      endcase
    end
  end

  logic       en;
  logic [7:1] vld;

  assign en = !vld[7] || results.ready;
  assign points.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:1], points.valid};
    end
  end

  // Stage 1: differences to the axis endpoints.
  logic signed [DW-1:0] p_in [3];
  logic signed [DW-1:0] s_in [3];
  logic signed [DW-1:0] e_in [3];
  logic signed [DW-1:0] s1_w [3];
  logic signed [DW-1:0] s1_v [3];
  logic signed [DW-1:0] s1_d [3];
  logic [W-2:0]         s1_r;

  assign p_in[0] = DW'(points.point_x);
  assign p_in[1] = DW'(points.point_y);
  assign p_in[2] = DW'(points.point_z);
  assign s_in[0] = DW'(start_x);
  assign s_in[1] = DW'(start_y);
  assign s_in[2] = DW'(start_z);
  assign e_in[0] = DW'(end_x);
  assign e_in[1] = DW'(end_y);
  assign e_in[2] = DW'(end_z);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_w[i] <= p_in[i] - s_in[i];
        s1_v[i] <= p_in[i] - e_in[i];
        s1_d[i] <= e_in[i] - s_in[i];
      end
      s1_r <= cap_radius;
    end
  end

  // Stage 2: products.
  logic signed [PW-1:0] ww_full [3];
  logic signed [PW-1:0] vv_full [3];
  logic signed [PW-1:0] dd_full [3];
  logic signed [PW-1:0] s2_tp [3];
  logic signed [PW-1:0] s2_ca [3];
  logic signed [PW-1:0] s2_cb [3];
  logic [SQW-1:0]       s2_ww [3];
  logic [SQW-1:0]       s2_vv [3];
  logic [SQW-1:0]       s2_dd [3];
  logic [RRW-1:0]       s2_rr;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ww_full[i] = s1_w[i] * s1_w[i];
      vv_full[i] = s1_v[i] * s1_v[i];
      dd_full[i] = s1_d[i] * s1_d[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_tp[i] <= s1_w[i] * s1_d[i];
        s2_ww[i] <= ww_full[i][SQW-1:0];
        s2_vv[i] <= vv_full[i][SQW-1:0];
        s2_dd[i] <= dd_full[i][SQW-1:0];
      end
      s2_ca[0] <= s1_w[1] * s1_d[2];
      s2_cb[0] <= s1_w[2] * s1_d[1];
      s2_ca[1] <= s1_w[2] * s1_d[0];
      s2_cb[1] <= s1_w[0] * s1_d[2];
      s2_ca[2] <= s1_w[0] * s1_d[1];
      s2_cb[2] <= s1_w[1] * s1_d[0];
      s2_rr    <= RRW'(s1_r * s1_r);
    end
  end

  // Stage 3: dot products and cross product.
  logic signed [TW-1:0] s3_t;
  logic [LW-1:0]        s3_ww, s3_vv, s3_len2;
  logic signed [CW-1:0] s3_c [3];
  logic [RRW-1:0]       s3_rr;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_t    <= TW'(s2_tp[0]) + TW'(s2_tp[1]) + TW'(s2_tp[2]);
      s3_ww   <= LW'(s2_ww[0]) + LW'(s2_ww[1]) + LW'(s2_ww[2]);
      s3_vv   <= LW'(s2_vv[0]) + LW'(s2_vv[1]) + LW'(s2_vv[2]);
      s3_len2 <= LW'(s2_dd[0]) + LW'(s2_dd[1]) + LW'(s2_dd[2]);
      for (int i = 0; i < 3; i++) begin
        s3_c[i] <= CW'(s2_ca[i] - s2_cb[i]);
      end
      s3_rr <= s2_rr;
    end
  end

  // Stage 4: region decision, cap tests and cross magnitudes.
  logic    cap_side, past_end;
  region_t region_next;
  logic    cap_in_next;

  assign cap_side = (s3_len2 == '0) || s3_t[TW-1];
  assign past_end = s3_t > $signed(TW'(s3_len2));

  always_comb begin
    priority if (cap_side) begin
      region_next = REGION_START;
      cap_in_next = s3_ww <= LW'(s3_rr);
    end else if (past_end) begin
      region_next = REGION_END;
      cap_in_next = s3_vv <= LW'(s3_rr);
    end else begin
      region_next = REGION_BODY;
      cap_in_next = 1'b0;
    end
  end

  logic [MW-1:0] s4_cm [3];
  logic [LW-1:0] s4_len2;
  logic [LW-1:0] s4_rr;
  region_t       s4_region;
  logic          s4_cap_in;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_cm[i] <= s3_c[i][CW-1] ? MW'(-s3_c[i]) : MW'(s3_c[i]);
      end
      s4_len2   <= s3_len2;
      s4_rr     <= LW'(s3_rr);
      s4_region <= region_next;
      s4_cap_in <= cap_in_next;
    end
  end

  // Stages 5 and 6: wide squares and the radius product in split multipliers.
  logic [2*MW-1:0] c_sq [3];
  logic [2*LW-1:0] rhs;

  for (genvar g = 0; g < 3; g++) begin : g_cross_sq
    pic_mul #(.WIDTH(MW)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (s4_cm[g]),
      .b   (s4_cm[g]),
      .p   (c_sq[g])
    );
  end

  pic_mul #(.WIDTH(LW)) u_rhs_mul (
    .clk (clk),
    .en  (en),
    .a   (s4_rr),
    .b   (s4_len2),
    .p   (rhs)
  );

  region_t s5_region, s6_region;
  logic    s5_cap_in, s6_cap_in;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_region <= s4_region;
      s5_cap_in <= s4_cap_in;
      s6_region <= s5_region;
      s6_cap_in <= s5_cap_in;
    end
  end

  // Stage 7: body compare and output register.
  logic [CMPW-1:0] lhs;
  logic            body_in;
  logic            s7_inside;
  region_t         s7_region;

  assign lhs     = CMPW'(c_sq[0]) + CMPW'(c_sq[1]) + CMPW'(c_sq[2]);
  assign body_in = lhs <= CMPW'(rhs);

  always_ff @(posedge clk) begin
    if (en) begin
      s7_region <= s6_region;
      s7_inside <= (s6_region == REGION_BODY) ? body_in : s6_cap_in;
    end
  end

  assign results.valid      = vld[7];
  assign results.inside_res = s7_inside;
  assign results.region     = s7_region;
endmodule
